[rtl/pida_pkg.sv]
// Package for the positional insert/delete array.
// Holds the item structs, the command and status codes and the cell control type.
// No dependencies.
`default_nettype none

package pida_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned POS_W         = 7;
  localparam int unsigned COUNT_W       = 7;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_UPDATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cmd_e                      cmd;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  read_data;
    logic [COUNT_W-1:0]        count;
  } rsp_t;

  typedef struct packed {
    cell_op_e                  op;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

  typedef struct packed {
    status_e                   status;
    logic                      rd_en;
  } ctrl_info_t;

endpackage

`default_nettype wire

[rtl/pida_cell.sv]
// One storage cell of the array chain, holding a single entry.
// Takes its neighbor's entry on a shift, or the new word on insert or update.
// Depends on pida_pkg.
`default_nettype none

module pida_cell
  import pida_pkg::*;
#(
  parameter int unsigned Depth = DEPTH_DEFAULT,
  parameter int unsigned Index = 0
) (
  input  wire logic                            clk_i,
  input  wire cell_ctrl_t                      ctrl_i,
  input  wire logic [$clog2(Depth+1)-1:0]      cnt_i,
  input  wire logic signed [DATA_W-1:0]        prev_i,
  input  wire logic signed [DATA_W-1:0]        next_i,
  output logic signed [DATA_W-1:0]             data_o,
  output logic                                 hit_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;

  logic [CmpW-1:0]            idx;
  logic [CmpW-1:0]            pos;
  logic [CmpW-1:0]            cnt;
  logic signed [DATA_W-1:0]   entry_d;
  logic signed [DATA_W-1:0]   entry_q;

  assign idx = CmpW'(Index);
  assign pos = CmpW'(ctrl_i.position);
  assign cnt = CmpW'(cnt_i);

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      OP_NONE: begin
        entry_d = entry_q;
      end
      OP_INSERT: begin
        if (idx == pos) begin
          entry_d = ctrl_i.value;
        end else if ((idx > pos) && (idx <= cnt)) begin
          entry_d = prev_i;
        end
      end
      OP_DELETE: begin
        if ((idx >= pos) && ((idx + CmpW'(1)) < cnt)) begin
          entry_d = next_i;
        end
      end
      OP_UPDATE: begin
        if (idx == pos) begin
          entry_d = ctrl_i.value;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;
  assign hit_o  = (idx == pos);

endmodule

`default_nettype wire

[rtl/pida_ctrl.sv]
// Request decoder and entry counter for the array chain.
// Checks each item against the count and drives the cell control broadcast.
// Depends on pida_pkg.
`default_nettype none

module pida_ctrl
  import pida_pkg::*;
#(
  parameter int unsigned Depth = DEPTH_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire req_t                          req_i,
  output cell_ctrl_t                         cell_ctrl_o,
  output ctrl_info_t                         info_o,
  output logic [$clog2(Depth+1)-1:0]         cnt_o,
  output logic [$clog2(Depth+1)-1:0]         cnt_next_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;

  logic [CntW-1:0] cnt_d;
  logic [CntW-1:0] cnt_q;
  logic [CmpW-1:0] pos_x;
  logic [CmpW-1:0] cnt_x;
  status_e         status;
  cell_op_e        op;

  assign pos_x = CmpW'(req_i.position);
  assign cnt_x = CmpW'(cnt_q);

  always_comb begin
    status = ST_DONE;
    if (req_i.cmd == CMD_INSERT) begin
      if (cnt_q == CntW'(Depth)) begin
        status = ST_FULL;
      end else if (pos_x > cnt_x) begin
        status = ST_BADPOS;
      end
    end else begin
      if (cnt_q == '0) begin
        status = ST_EMPTY;
      end else if (pos_x >= cnt_x) begin
        status = ST_BADPOS;
      end
    end
  end

  always_comb begin
    op    = OP_NONE;
    cnt_d = cnt_q;
    if (accept_i && (status == ST_DONE)) begin
      unique case (req_i.cmd)
        CMD_READ: begin
          op = OP_NONE;
        end
        CMD_INSERT: begin
          op    = OP_INSERT;
          cnt_d = cnt_q + CntW'(1);
        end
        CMD_DELETE: begin
          op    = OP_DELETE;
          cnt_d = cnt_q - CntW'(1);
        end
        CMD_UPDATE: begin
          op = OP_UPDATE;
        end
        default: begin
          op = OP_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cell_ctrl_o.op       = op;
  assign cell_ctrl_o.position = req_i.position;
  assign cell_ctrl_o.value    = req_i.value;
  assign info_o.status        = status;
  assign info_o.rd_en         = (status == ST_DONE) &&
                                ((req_i.cmd == CMD_READ) || (req_i.cmd == CMD_UPDATE));
  assign cnt_o                = cnt_q;
  assign cnt_next_o           = cnt_d;

endmodule

`default_nettype wire

[rtl/positional_insert_delete_array.sv]
// Top level of the positional insert/delete array: a chain of entry cells and a decoder.
// Depends on pida_pkg, pida_ctrl and pida_cell.
//
// The block takes one item in every clock cycle and returns its result on rsp_o,
// marked by result_valid_o, in the cycle right after start was seen high; busy is
// always low. Each cell that shifts moves its entry to or from a neighbor at the same
// edge, so an insert or delete anywhere in the list is done at once. Results must be
// taken as they come, since the block has no way to hold them.
`default_nettype none

module positional_insert_delete_array
  import pida_pkg::*;
#(
  parameter int unsigned Depth = DEPTH_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      result_valid_o,
  output rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  cell_ctrl_t                cell_ctrl;
  ctrl_info_t                info;
  logic [CntW-1:0]           cnt;
  logic [CntW-1:0]           cnt_next;
  logic signed [DATA_W-1:0]  cell_data [Depth];
  logic [Depth-1:0]          hit;
  logic signed [DATA_W-1:0]  rd_data;
  logic                      accept;
  logic                      valid_q;
  rsp_t                      rsp_d;
  rsp_t                      rsp_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pida_ctrl #(
    .Depth(Depth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req_i),
    .cell_ctrl_o(cell_ctrl),
    .info_o     (info),
    .cnt_o      (cnt),
    .cnt_next_o (cnt_next)
  );

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev;
    logic signed [DATA_W-1:0] next;

    if (i == 0) begin : g_first
      assign prev = cell_ctrl.value;
    end else begin : g_prev
      assign prev = cell_data[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign next = cell_data[i];
    end else begin : g_next
      assign next = cell_data[i+1];
    end

    pida_cell #(
      .Depth(Depth),
      .Index(i)
    ) u_cell (
      .clk_i (clk_i),
      .ctrl_i(cell_ctrl),
      .cnt_i (cnt),
      .prev_i(prev),
      .next_i(next),
      .data_o(cell_data[i]),
      .hit_o (hit[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < Depth; i++) begin
      rd_data = rd_data | ({DATA_W{hit[i]}} & cell_data[i]);
    end
  end

  always_comb begin
    rsp_d.status    = info.status;
    rsp_d.read_data = info.rd_en ? rd_data : '0;
    rsp_d.count     = COUNT_W'(cnt_next);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

`ifndef SYNTHESIS
  a_result_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> result_valid_o)
    else $error("An accepted item produced no result.");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |=> !result_valid_o)
    else $error("A result appeared without an accepted item.");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= CntW'(Depth))
    else $error("The entry count exceeds the array depth.");

  a_reject_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status != ST_DONE)) |-> (cnt == $past(cnt)))
    else $error("A rejected item changed the entry count.");

  a_reject_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status != ST_DONE)) |-> (rsp_o.read_data == '0))
    else $error("A rejected item returned nonzero data.");
`endif

endmodule

`default_nettype wire
